[hdl/rvs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rank transform package
// Shared sizes, payload types and control structs of the rank transform.
// ----------------------------------------------------------------------------
package rvs_pkg;

  // Largest set that one bank of the value store holds.
  localparam int MAX_COUNT = 64;
  localparam int IDX_W = $clog2(MAX_COUNT);
  localparam int CNT_W = $clog2(MAX_COUNT + 1);
  // Two banks: one set loads while the other is ranked.
  localparam int BANKS = 2;
  localparam int BANK_W = 1;
  localparam int ADDR_W = BANK_W + IDX_W;
  localparam int DATA_W = 32;
  localparam int RANK_W = 6;
  localparam int JOB_Q_DEPTH = 2;
  localparam int JOB_PTR_W = 1;
  localparam int JOB_FILL_W = 2;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } req_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              final_res;
    logic              overflow;
  } rsp_t;

  // One closed set waiting to be ranked.
  typedef struct packed {
    logic [BANK_W-1:0] bank;
    logic [CNT_W-1:0]  count;
    logic              dropped;
  } job_t;

  // Store write port.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } wr_t;

  // Bank hand-back from the ranking side to the loading side.
  typedef struct packed {
    logic              valid;
    logic [BANK_W-1:0] bank;
  } rel_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_READ_I,
    B_CAP_I,
    B_SCAN,
    B_EMIT
  } back_state_t;

endpackage
`default_nettype wire

[hdl/rvs_store.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Value store
// Banked value memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module rvs_store (
  input  wire logic                        clk,
  input  wire rvs_pkg::wr_t                wr,
  input  wire logic [rvs_pkg::ADDR_W-1:0]  rd_addr,
  output logic      [rvs_pkg::DATA_W-1:0]  rd_data
);
  import rvs_pkg::*;

  logic [DATA_W-1:0] mem [BANKS*MAX_COUNT];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

[hdl/rvs_job_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Job queue
// Short queue of closed sets between the loading and the ranking side.
// ----------------------------------------------------------------------------
module rvs_job_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire rvs_pkg::job_t push_job,
  output logic               full,
  input  wire logic          pop,
  output logic               pop_valid,
  output rvs_pkg::job_t      pop_job
);
  import rvs_pkg::*;

  job_t                  entries [JOB_Q_DEPTH];
  logic [JOB_PTR_W-1:0]  wr_ptr;
  logic [JOB_PTR_W-1:0]  rd_ptr;
  logic [JOB_FILL_W-1:0] fill;
  logic                  do_push;
  logic                  do_pop;

  assign full      = (fill == JOB_FILL_W'(JOB_Q_DEPTH));
  assign pop_valid = (fill != '0);
  assign pop_job   = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule
`default_nettype wire

[hdl/rvs_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Loading side
// Accepts requests, writes values into the free bank and closes sets.
// ----------------------------------------------------------------------------
module rvs_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire rvs_pkg::req_t req_data,
  output rvs_pkg::wr_t       wr,
  output logic               job_push,
  output rvs_pkg::job_t      job,
  input  wire logic          job_full,
  input  wire rvs_pkg::rel_t rel
);
  import rvs_pkg::*;

  logic [BANK_W-1:0] wbank;
  logic [CNT_W-1:0]  count;
  logic              dropped;
  logic [BANKS-1:0]  bank_full;
  logic              take;
  logic              has_room;

  assign req_ready = !bank_full[wbank] && !job_full;
  assign take      = req_valid && req_ready;
  assign has_room  = (count < CNT_W'(MAX_COUNT));

  always_comb begin
    wr.en   = take && has_room;
    wr.addr = {wbank, count[IDX_W-1:0]};
    wr.data = req_data.value;
  end

  // The closing request's own value is already counted here.
  always_comb begin
    job_push    = take && req_data.last;
    job.bank    = wbank;
    job.count   = has_room ? count + 1'b1 : count;
    job.dropped = dropped || !has_room;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wbank     <= '0;
      count     <= '0;
      dropped   <= 1'b0;
      bank_full <= '0;
    end else begin
      if (rel.valid) begin
        bank_full[rel.bank] <= 1'b0;
      end
      if (take) begin
        if (req_data.last) begin
          bank_full[wbank] <= 1'b1;
          wbank            <= wbank + 1'b1;
          count            <= '0;
          dropped          <= 1'b0;
        end else if (has_room) begin
          count <= count + 1'b1;
        end else begin
          dropped <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

[hdl/rvs_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ranking side
// Ranks each value of a closed set with one comparator, in load order.
// ----------------------------------------------------------------------------
module rvs_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        job_valid,
  input  wire rvs_pkg::job_t               job,
  output logic                             job_pop,
  output logic      [rvs_pkg::ADDR_W-1:0]  rd_addr,
  input  wire logic [rvs_pkg::DATA_W-1:0]  rd_data,
  output rvs_pkg::rel_t                    rel,
  output logic                             rsp_valid,
  input  wire logic                        rsp_ready,
  output rvs_pkg::rsp_t                    rsp_data
);
  import rvs_pkg::*;

  back_state_t       state;
  back_state_t       state_next;
  job_t              cur;
  logic [IDX_W-1:0]  i;
  logic [CNT_W-1:0]  j;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] vi;
  logic              slot_free;
  logic              is_final;
  logic              scan_done;
  logic              le;
  logic              emit;
  logic [IDX_W-1:0]  rd_idx;

  assign slot_free = !rsp_valid || rsp_ready;
  assign is_final  = (CNT_W'(i) + 1'b1 == cur.count);
  assign scan_done = (j == cur.count);
  assign le        = ($signed(rd_data) <= $signed(vi));

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (job_valid) begin
          state_next = B_READ_I;
        end
      end
      B_READ_I: state_next = B_CAP_I;
      B_CAP_I:  state_next = B_SCAN;
      B_SCAN: begin
        if (scan_done) begin
          state_next = B_EMIT;
        end
      end
      B_EMIT: begin
        if (slot_free) begin
          state_next = is_final ? B_IDLE : B_READ_I;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    job_pop = 1'b0;
    emit    = 1'b0;
    rd_idx  = i;
    unique case (state)
      B_IDLE:   job_pop = job_valid;
      B_READ_I: rd_idx = i;
      B_CAP_I:  rd_idx = '0;
      B_SCAN:   rd_idx = j[IDX_W-1:0];
      B_EMIT:   emit = slot_free;
      default:  rd_idx = i;
    endcase
    rd_addr   = {cur.bank, rd_idx};
    rel.valid = emit && is_final;
    rel.bank  = cur.bank;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      cur <= job;
      i   <= '0;
    end
    if (state == B_CAP_I) begin
      vi  <= rd_data;
      j   <= CNT_W'(1);
      cnt <= '0;
    end
    if (state == B_SCAN) begin
      cnt <= cnt + CNT_W'(le);
      if (!scan_done) begin
        j <= j + 1'b1;
      end
    end
    if (emit) begin
      i                  <= i + 1'b1;
      rsp_data.rank      <= RANK_W'(cnt - 1'b1);
      rsp_data.final_res <= is_final;
      rsp_data.overflow  <= cur.dropped;
    end
  end

endmodule
`default_nettype wire

[hdl/rank_values_by_sort_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rank transform top level
// Loads sets of signed values and returns each value's ascending sort rank.
// ----------------------------------------------------------------------------
// Each request carries one signed 32-bit value; the request with last set
// closes the set. Up to 64 values of a set are kept; later ones are dropped
// and every response of that set then reports overflow. After the set closes,
// one response per kept value comes out in load order, giving the number of
// kept values less than or equal to it, minus one, so equal values share the
// highest of their sorted positions. The last response of a set has
// final_res set. Requests load at one per cycle, while the write bank is
// free and the job queue is not full, into one bank of a two-bank store
// while the other bank is ranked, so a second set can load while the first
// is still being ranked; a third set waits until the last response of the
// first has been registered at the output. Ranking uses a single
// comparator that reads the store one entry per cycle: each response of a
// set with n values reads the value, captures it, makes n compares and
// registers the response, which the response side may hold off.
// ----------------------------------------------------------------------------
module rank_values_by_sort_top (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire rvs_pkg::req_t req_data,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output rvs_pkg::rsp_t      rsp_data
);
  import rvs_pkg::*;

  // Store write from the loading side, read from the ranking side.
  wr_t               wr;
  logic [ADDR_W-1:0] rd_addr;
  logic [DATA_W-1:0] rd_data;

  // Closed sets travel through the job queue.
  logic job_push;
  job_t job_in;
  logic job_full;
  logic job_pop;
  logic job_valid;
  job_t job_out;

  // A bank returns to the loading side once its last response is registered.
  rel_t rel;

  rvs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .wr        (wr),
    .job_push  (job_push),
    .job       (job_in),
    .job_full  (job_full),
    .rel       (rel)
  );

  rvs_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rvs_job_fifo u_job_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_job  (job_in),
    .full      (job_full),
    .pop       (job_pop),
    .pop_valid (job_valid),
    .pop_job   (job_out)
  );

  rvs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job_out),
    .job_pop   (job_pop),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .rel       (rel),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

endmodule
`default_nettype wire
